### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/svf_pkg.sv
// ---------------------------------------------------------------------------
// svf_pkg
// Types, widths and helpers shared by the bandpass bank cells and top level.
// ---------------------------------------------------------------------------
package svf_pkg;

	localparam int SAMPLE_W = 24;
	localparam int COEF_W   = 18;
	localparam int WET_W    = 17;
	localparam int INT_W    = 32;
	localparam int V3_W     = 33;
	localparam int PROD_W   = 52;
	localparam int V_W      = 34;
	localparam int UPD_W    = 37;
	localparam int FRAC_SH  = 18;
	localparam int MIX_SH   = 16;

	localparam logic [WET_W-1:0] WET_ONE = 17'd65536;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_LOAD   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	// sample token walking down the cell row
	typedef struct packed {
		logic                       vld;
		logic signed [SAMPLE_W-1:0] x;
	} tok_t;

	// load / clear broadcast to the cells
	typedef struct packed {
		logic              load;
		logic              clear;
		logic [COEF_W-1:0] a1;
		logic [COEF_W-1:0] a2;
		logic [COEF_W-1:0] a3;
		logic [COEF_W-1:0] gain;
	} cell_ctl_t;

	// clamp an integrator update to signed 32 bits
	function automatic logic signed [INT_W-1:0] sat_int(input logic signed [UPD_W-1:0] v);
		logic signed [UPD_W-1:0] hi;
		logic signed [UPD_W-1:0] lo;
		hi = UPD_W'(signed'({1'b0, {(INT_W-1){1'b1}}}));
		lo = -hi - UPD_W'(1);
		if (v > hi) begin
			return INT_W'(hi);
		end else if (v < lo) begin
			return INT_W'(lo);
		end
		return INT_W'(v);
	endfunction

endpackage

### hw/rtl/svf_cell.sv
// ---------------------------------------------------------------------------
// svf_cell
// One SVF bandpass band: integrators, coefficients, and a 3-stage update
// that forwards the sample token and the running weighted sum.
// ---------------------------------------------------------------------------
module svf_cell #(
	parameter int ACC_W = 58
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  svf_pkg::cell_ctl_t        ctl,
	input  svf_pkg::tok_t             tok_in,
	input  logic signed [ACC_W-1:0]   acc_in,
	output svf_pkg::tok_t             tok_out,
	output logic signed [ACC_W-1:0]   acc_out,
	output logic                      acc_vld
);

	localparam int PW = svf_pkg::PROD_W;
	localparam int VW = svf_pkg::V_W;
	localparam int UW = svf_pkg::UPD_W;

	logic signed [svf_pkg::INT_W-1:0] s1_q, s2_q;
	logic [svf_pkg::COEF_W-1:0] a1_q, a2_q, a3_q, gain_q;

	logic signed [PW-1:0] p11_s1, p12_s1, p21_s1, p22_s1;
	logic                 vld_s1;
	logic signed [svf_pkg::SAMPLE_W-1:0] x_s1;
	logic signed [VW-1:0] v1_s2;
	logic                 vld_s2;
	logic signed [ACC_W-1:0] acc_s3;
	logic                    vld_s3;

	logic signed [svf_pkg::V3_W-1:0] v3;
	logic signed [PW-1:0] sum1, sum2;
	logic signed [VW-1:0] v1, r2;
	logic signed [UW-1:0] v2, new1, new2;

	// stage 1: four coefficient products
	assign v3 = svf_pkg::V3_W'(tok_in.x) - svf_pkg::V3_W'(s2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.vld) begin
			x_s1   <= tok_in.x;
			p11_s1 <= PW'(signed'({1'b0, a1_q})) * PW'(s1_q);
			p12_s1 <= PW'(signed'({1'b0, a2_q})) * PW'(v3);
			p21_s1 <= PW'(signed'({1'b0, a2_q})) * PW'(s1_q);
			p22_s1 <= PW'(signed'({1'b0, a3_q})) * PW'(v3);
		end
	end

	assign tok_out = '{vld: vld_s1, x: x_s1};

	// stage 2: round, form v1/v2, update integrators
	assign sum1 = p11_s1 + p12_s1 + (PW'(1) <<< (svf_pkg::FRAC_SH - 1));
	assign sum2 = p21_s1 + p22_s1 + (PW'(1) <<< (svf_pkg::FRAC_SH - 1));
	assign v1   = VW'(sum1 >>> svf_pkg::FRAC_SH);
	assign r2   = VW'(sum2 >>> svf_pkg::FRAC_SH);
	assign v2   = UW'(s2_q) + UW'(r2);
	assign new1 = (UW'(v1) <<< 1) - UW'(s1_q);
	assign new2 = (v2 <<< 1) - UW'(s2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			s1_q   <= '0;
			s2_q   <= '0;
			a1_q   <= '0;
			a2_q   <= '0;
			a3_q   <= '0;
			gain_q <= '0;
		end else begin
			vld_s2 <= vld_s1;
			if (ctl.clear) begin
				s1_q <= '0;
				s2_q <= '0;
			end else if (vld_s1) begin
				s1_q <= svf_pkg::sat_int(new1);
				s2_q <= svf_pkg::sat_int(new2);
			end
			if (ctl.load) begin
				a1_q   <= ctl.a1;
				a2_q   <= ctl.a2;
				a3_q   <= ctl.a3;
				gain_q <= ctl.gain;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			v1_s2 <= v1;
		end
	end

	// stage 3: add this band's weighted output to the running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_s3 <= acc_in + ACC_W'(v1_s2) * ACC_W'(signed'({1'b0, gain_q}));
		end
	end

	assign acc_out = acc_s3;
	assign acc_vld = vld_s3;

endmodule

### hw/rtl/svf_bandpass_bank_mix.sv
// ---------------------------------------------------------------------------
// svf_bandpass_bank_mix
// Bank of trapezoidal SVF bandpass filters with gain-weighted sum and dry/wet
// mix.
// ---------------------------------------------------------------------------
// Each accepted sample item is registered, then walks the row of band cells
// one cell per cycle; the last cell's running sum then passes the tail
// (bank rounding, mix products, final rounding and saturation) on its way
// to the output register. One sample is in flight at a time; the next one
// is taken once the previous result has left the mix stage, even while that
// result still waits at the output. Load (op 1) and clear (op 2) items are
// taken when no sample is in flight and produce no result. wet_mix writes
// are accepted at any time and must be done while the block is idle.
module svf_bandpass_bank_mix #(
	parameter int NUM_BANDS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [svf_pkg::WET_W-1:0]           wet_mix,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          op,
	input  logic signed [svf_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [3:0]                          band_index,
	input  logic [svf_pkg::COEF_W-1:0]          coef_one,
	input  logic [svf_pkg::COEF_W-1:0]          coef_two,
	input  logic [svf_pkg::COEF_W-1:0]          coef_three,
	input  logic [svf_pkg::COEF_W-1:0]          band_gain,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [svf_pkg::SAMPLE_W-1:0] sample_out
);

	`include "assert_macros.svh"

	localparam int ACC_W  = 54 + $clog2(NUM_BANDS);
	localparam int BANK_W = ACC_W - svf_pkg::FRAC_SH;
	localparam int WP_W   = BANK_W + 19;
	localparam int MIX_W  = WP_W + 1;
	localparam int RES_W  = MIX_W - svf_pkg::MIX_SH;
	localparam int SW     = svf_pkg::SAMPLE_W;

	logic [svf_pkg::WET_W-1:0] wet_q;
	logic                      run_q;
	logic                      start_q;
	logic signed [SW-1:0]      x_q;
	logic                      f1_vld_q, f2_vld_q, out_vld_q;
	logic signed [BANK_W-1:0]  bank_s1;
	logic signed [WP_W-1:0]    wetp_s2;
	logic signed [42:0]        dryp_s2;
	logic signed [SW-1:0]      out_q;

	logic                      acc_in, do_load, do_clear, do_sample, move_out;
	logic [svf_pkg::WET_W-1:0] wet_eff, dry_f;
	logic [18:0]               wet3;
	logic signed [MIX_W-1:0]   mix;
	logic signed [RES_W-1:0]   res;

	svf_pkg::tok_t             tok [NUM_BANDS+1];
	logic signed [ACC_W-1:0]   acc [NUM_BANDS+1];
	logic                      accv[NUM_BANDS];

	// config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_q <= svf_pkg::WET_ONE;
		end else if (cfg_valid) begin
			wet_q <= wet_mix;
		end
	end

	// input decode
	assign in_stall = run_q;
	assign acc_in   = in_valid && !run_q;

	always_comb begin
		do_sample = 1'b0;
		do_load   = 1'b0;
		do_clear  = 1'b0;
		case (svf_pkg::op_t'(op))
			svf_pkg::OP_SAMPLE: do_sample = acc_in;
			svf_pkg::OP_LOAD:   do_load   = acc_in;
			svf_pkg::OP_CLEAR:  do_clear  = acc_in;
			default: ;
		endcase
	end

	assign move_out = f2_vld_q && (!out_vld_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= do_sample;
			if (do_sample) begin
				run_q <= 1'b1;
			end else if (move_out) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_sample) begin
			x_q <= sample_in;
		end
	end

	// row of band cells
	assign tok[0] = '{vld: start_q, x: x_q};
	assign acc[0] = '0;

	for (genvar i = 0; i < NUM_BANDS; i++) begin : g_cell
		svf_pkg::cell_ctl_t ctl;
		assign ctl = '{
			load:  do_load && (32'(band_index) == i),
			clear: do_clear,
			a1:    coef_one,
			a2:    coef_two,
			a3:    coef_three,
			gain:  band_gain
		};
		svf_cell #(.ACC_W(ACC_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tok_in  (tok[i]),
			.acc_in  (acc[i]),
			.tok_out (tok[i+1]),
			.acc_out (acc[i+1]),
			.acc_vld (accv[i])
		);
	end

	// tail: bank rounding, mix products, final round and saturate
	assign wet_eff = (wet_q > svf_pkg::WET_ONE) ? svf_pkg::WET_ONE : wet_q;
	assign dry_f   = svf_pkg::WET_ONE - wet_eff;
	assign wet3    = 19'(wet_eff) + (19'(wet_eff) << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f1_vld_q  <= 1'b0;
			f2_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			f1_vld_q <= accv[NUM_BANDS-1];
			if (f1_vld_q) begin
				f2_vld_q <= 1'b1;
			end else if (move_out) begin
				f2_vld_q <= 1'b0;
			end
			if (move_out) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accv[NUM_BANDS-1]) begin
			bank_s1 <= BANK_W'((acc[NUM_BANDS] + (ACC_W'(1) <<< (svf_pkg::FRAC_SH - 1)))
				>>> svf_pkg::FRAC_SH);
		end
		if (f1_vld_q) begin
			wetp_s2 <= WP_W'(signed'({1'b0, wet3})) * WP_W'(bank_s1);
			dryp_s2 <= 43'(signed'({1'b0, dry_f})) * 43'(x_q);
		end
	end

	assign mix = MIX_W'(wetp_s2) + MIX_W'(dryp_s2) + (MIX_W'(1) <<< (svf_pkg::MIX_SH - 1));
	assign res = RES_W'(mix >>> svf_pkg::MIX_SH);

	always_ff @(posedge clk) begin
		if (move_out) begin
			if (res > RES_W'(signed'({1'b0, {(SW-1){1'b1}}}))) begin
				out_q <= {1'b0, {(SW-1){1'b1}}};
			end else if (res < -RES_W'(signed'({1'b0, {(SW-1){1'b1}}})) - RES_W'(1)) begin
				out_q <= {1'b1, {(SW-1){1'b0}}};
			end else begin
				out_q <= SW'(res);
			end
		end
	end

	assign out_valid  = out_vld_q;
	assign sample_out = out_q;

	// checks
	`ASSERT_NEXT(a_sample_runs, do_sample, run_q)
	`ASSERT_SAME(a_tail_in_run, f1_vld_q || f2_vld_q, run_q)
	`ASSERT_SAME(a_one_in_tail, accv[NUM_BANDS-1], !f2_vld_q && !f1_vld_q)
	`ASSERT_SAME(a_no_load_busy, do_load || do_clear, !run_q && !tok[0].vld)

endmodule

### sim/svf_bandpass_bank_mix_checker.sv
// ----------------------------------------------------------------------------
// svf_bandpass_bank_mix_checker
// Watches the config, input and output channels of the bandpass bank. Keeps a
// bit-exact filter bank model, queues the predicted output samples and
// compares each accepted output item against the oldest prediction.
// ----------------------------------------------------------------------------
module svf_bandpass_bank_mix_checker #(
	parameter int NUM_BANDS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [svf_pkg::WET_W-1:0]           wet_mix,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [1:0]                          op,
	input  logic signed [svf_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [3:0]                          band_index,
	input  logic [svf_pkg::COEF_W-1:0]          coef_one,
	input  logic [svf_pkg::COEF_W-1:0]          coef_two,
	input  logic [svf_pkg::COEF_W-1:0]          coef_three,
	input  logic [svf_pkg::COEF_W-1:0]          band_gain,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [svf_pkg::SAMPLE_W-1:0] sample_out,
	output int                                  samples_pending,
	output int                                  mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WET_W    = svf_pkg::WET_W;
	localparam int SAMPLE_W = svf_pkg::SAMPLE_W;
	localparam int COEF_W   = svf_pkg::COEF_W;
	localparam int FRAC_SH  = svf_pkg::FRAC_SH;
	localparam int MIX_SH   = svf_pkg::MIX_SH;
	localparam logic [WET_W-1:0] WET_ONE = svf_pkg::WET_ONE;

	localparam longint INT_MAX_L = 64'sd2147483647;
	localparam longint INT_MIN_L = -64'sd2147483648;
	localparam longint OUT_MAX_L = 64'sd8388607;
	localparam longint OUT_MIN_L = -64'sd8388608;

	// model state
	logic [WET_W-1:0]        wet_frac;
	longint                  state_lp[NUM_BANDS];
	longint                  state_bp[NUM_BANDS];
	logic [COEF_W-1:0]       k_a1[NUM_BANDS];
	logic [COEF_W-1:0]       k_a2[NUM_BANDS];
	logic [COEF_W-1:0]       k_a3[NUM_BANDS];
	logic [COEF_W-1:0]       k_gain[NUM_BANDS];
	logic signed [SAMPLE_W-1:0] expected_samples[$];

	// round half up from a shift of sh bits (>>> on longint floors)
	function automatic longint round_down_by(input longint v, input int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		if (v < lo) begin
			return lo;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// run one sample through every band and the dry/wet mix
	function automatic logic signed [SAMPLE_W-1:0] filter_bank_step(
		input logic signed [SAMPLE_W-1:0] smp);
		longint x, s1, s2, v1, v2, v3, acc, bank, wet, mix;
		x = longint'(smp);
		acc = 0;
		for (int b = 0; b < NUM_BANDS; b++) begin
			s1 = state_bp[b];
			s2 = state_lp[b];
			v3 = x - s2;
			v1 = round_down_by(longint'(k_a1[b]) * s1 + longint'(k_a2[b]) * v3, FRAC_SH);
			v2 = s2 + round_down_by(longint'(k_a2[b]) * s1 + longint'(k_a3[b]) * v3,
				FRAC_SH);
			state_bp[b] = clamp(2 * v1 - s1, INT_MIN_L, INT_MAX_L);
			state_lp[b] = clamp(2 * v2 - s2, INT_MIN_L, INT_MAX_L);
			acc += v1 * longint'(k_gain[b]);
		end
		bank = round_down_by(acc, FRAC_SH);
		wet = (wet_frac > WET_ONE) ? longint'(WET_ONE) : longint'(wet_frac);
		mix = (longint'(WET_ONE) - wet) * x + wet * 3 * bank;
		return SAMPLE_W'(clamp(round_down_by(mix, MIX_SH), OUT_MIN_L, OUT_MAX_L));
	endfunction

	assign samples_pending = expected_samples.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_frac <= WET_ONE;
			for (int b = 0; b < NUM_BANDS; b++) begin
				state_bp[b] = 0;
				state_lp[b] = 0;
				k_a1[b] = '0;
				k_a2[b] = '0;
				k_a3[b] = '0;
				k_gain[b] = '0;
			end
			expected_samples.delete();
			mismatch_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				wet_frac <= wet_mix;
			end
			// input item accepted: update model
			if (in_valid && !in_stall) begin
				case (op)
					svf_pkg::OP_SAMPLE: begin
						expected_samples.push_back(filter_bank_step(sample_in));
					end
					svf_pkg::OP_LOAD: begin
						if (int'(band_index) < NUM_BANDS) begin
							k_a1[band_index] = coef_one;
							k_a2[band_index] = coef_two;
							k_a3[band_index] = coef_three;
							k_gain[band_index] = band_gain;
						end
					end
					svf_pkg::OP_CLEAR: begin
						for (int b = 0; b < NUM_BANDS; b++) begin
							state_bp[b] = 0;
							state_lp[b] = 0;
						end
					end
					default: ;
				endcase
			end
			// output item accepted: compare
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected output item, actual sample_out %0d",
						$time, sample_out);
					mismatch_count <= mismatch_count + 1;
				end else begin
					if (sample_out !== expected_samples[0]) begin
						$display("%0t: sample_out mismatch, expected %0d actual %0d",
							$time, expected_samples[0], sample_out);
						mismatch_count <= mismatch_count + 1;
					end
					void'(expected_samples.pop_front());
				end
			end
		end
	end

endmodule

### sim/tb_svf_bandpass_bank_mix.sv
// ----------------------------------------------------------------------------
// tb_svf_bandpass_bank_mix
// Drives coefficient loads, integrator clears and audio samples into the
// bandpass bank across several wet settings, with random idle bursts on
// both channels; the checker predicts and compares every output sample.
// ----------------------------------------------------------------------------
module tb_svf_bandpass_bank_mix;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WET_W    = svf_pkg::WET_W;
	localparam int SAMPLE_W = svf_pkg::SAMPLE_W;
	localparam int COEF_W   = svf_pkg::COEF_W;
	localparam logic [WET_W-1:0] WET_ONE = svf_pkg::WET_ONE;

	localparam int NUM_BANDS  = 16;
	localparam int DRAIN_WAIT = NUM_BANDS + 14;
	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;
	localparam logic [COEF_W-1:0]          COEF_MAX = 18'h3FFFF;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [WET_W-1:0]           wet_mix;
	logic                       in_valid;
	logic                       in_stall;
	logic [1:0]                 op;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic [3:0]                 band_index;
	logic [COEF_W-1:0]          coef_one;
	logic [COEF_W-1:0]          coef_two;
	logic [COEF_W-1:0]          coef_three;
	logic [COEF_W-1:0]          band_gain;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] sample_out;
	int                         samples_pending;
	int                         mismatch_count;
	bit                         calm_mode;

	svf_bandpass_bank_mix #(.NUM_BANDS(NUM_BANDS)) u_dut (.*);

	svf_bandpass_bank_mix_checker #(.NUM_BANDS(NUM_BANDS)) u_checker (.*);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// watchdog
	initial begin
		#5ms;
		$display("svf_bandpass_bank_mix verification failed");
		$finish;
	end

	// output backpressure in random bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!calm_mode && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// one item, held until accepted
	task automatic send_item(input logic [1:0] o, input logic signed [SAMPLE_W-1:0] smp,
		input logic [3:0] bi, input logic [COEF_W-1:0] c1, input logic [COEF_W-1:0] c2,
		input logic [COEF_W-1:0] c3, input logic [COEF_W-1:0] g);
		op         <= o;
		sample_in  <= smp;
		band_index <= bi;
		coef_one   <= c1;
		coef_two   <= c2;
		coef_three <= c3;
		band_gain  <= g;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (!calm_mode && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
		send_item(svf_pkg::OP_SAMPLE, smp, 4'($urandom), 18'($urandom), 18'($urandom),
			18'($urandom), 18'($urandom));
	endtask

	// a band with a plausible (mostly stable) coefficient set, or full-range noise
	task automatic load_band(input logic [3:0] bi);
		logic [COEF_W-1:0] c1, c2, c3;
		if ($urandom_range(0, 4) == 0) begin
			send_item(svf_pkg::OP_LOAD, SAMPLE_W'($urandom), bi, 18'($urandom),
				18'($urandom), 18'($urandom), 18'($urandom));
		end else begin
			c1 = 18'($urandom_range(100000, COEF_MAX));
			c2 = 18'($urandom_range(0, 120000));
			c3 = 18'((longint'(c2) * $urandom_range(0, 120000)) >> 18);
			send_item(svf_pkg::OP_LOAD, SAMPLE_W'($urandom), bi, c1, c2, c3,
				18'($urandom_range(0, 90000)));
		end
	endtask

	// wet write only once the bank has drained
	task automatic write_wet(input logic [WET_W-1:0] w);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (samples_pending == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		wet_mix   <= w;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				if ($urandom_range(0, 5) == 0) begin
					send_sample($urandom_range(0, 1) ? SMP_MAX : SMP_MIN);
				end else begin
					send_sample(SAMPLE_W'($urandom));
				end
			end else if (pick < 92) begin
				load_band(4'($urandom));
			end else if (pick < 97) begin
				send_item(svf_pkg::OP_CLEAR, SAMPLE_W'($urandom), 4'($urandom),
					18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
			end else begin
				send_item(svf_pkg::OP_NOP, SAMPLE_W'($urandom), 4'($urandom),
					18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
			end
		end
	endtask

	initial begin
		calm_mode  = 1'b0;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		wet_mix    = WET_ONE;
		in_valid   = 1'b0;
		op         = svf_pkg::OP_SAMPLE;
		sample_in  = '0;
		band_index = '0;
		coef_one   = '0;
		coef_two   = '0;
		coef_three = '0;
		band_gain  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: sample through an all-zero bank, then extreme loads
		send_sample(SMP_MAX);
		send_item(svf_pkg::OP_LOAD, '0, 4'd0, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		send_item(svf_pkg::OP_LOAD, '0, 4'd15, '0, '0, '0, '0);
		send_item(svf_pkg::OP_LOAD, '0, 4'd5, 18'd230000, 18'd20000, 18'd1500,
			18'd131072);
		send_item(svf_pkg::OP_LOAD, '0, 4'd10, 18'd250000, 18'd60000, 18'd14000,
			COEF_MAX);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		send_sample('0);
		send_sample(SAMPLE_W'(-1));
		// unstable band 0 drives integrators into saturation
		repeat (6) send_sample(SMP_MAX);
		repeat (6) send_sample(SMP_MIN);
		send_item(svf_pkg::OP_NOP, SMP_MAX, 4'd15, COEF_MAX, COEF_MAX, COEF_MAX,
			COEF_MAX);
		send_item(svf_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0);
		send_sample(SMP_MAX);
		send_item(svf_pkg::OP_LOAD, '0, 4'd0, '0, '0, '0, '0);
		send_sample(SMP_MIN);

		// wet sweep incl. zero, above one and the nominal maximum
		write_wet('0);
		random_phase(80);
		write_wet(17'h1FFFF);
		random_phase(80);
		write_wet(WET_ONE + 17'd1);
		random_phase(40);
		write_wet(17'($urandom_range(1, 65535)));
		random_phase(100);
		write_wet(WET_ONE);
		calm_mode = 1'b1;
		random_phase(100);
		in_valid <= 1'b0;
		@(posedge clk);

		wait (samples_pending == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("svf_bandpass_bank_mix verification clean");
		end else begin
			$display("svf_bandpass_bank_mix verification failed");
		end
		$finish;
	end

endmodule
